[src/matrix_frame_deframer_max_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the matrix frame deframer
// Shared concurrent-assertion shorthands, clocked on clk_i and disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_FRAME_DEFRAMER_MAX_MACROS_SVH
`define MATRIX_FRAME_DEFRAMER_MAX_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFDM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MFDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/mfdm_pkg.sv]
// ----------------------------------------------------------------------------
// Matrix frame deframer package
// Frame geometry, field widths, status codes and the shared unit's types.
// ----------------------------------------------------------------------------
package mfdm_pkg;

  // Frame geometry.
  localparam int POINTS    = 16;
  localparam int FRAME_LEN = 2 * POINTS + 5;
  localparam int CHK_POS   = 2 + 2 * POINTS;
  localparam int POS_W     = $clog2(FRAME_LEN);
  localparam int ADDR_W    = (POINTS > 1) ? $clog2(POINTS) : 1;

  // Result field widths.
  localparam int STATUS_W = 2;
  localparam int PIDX_W   = 4;
  localparam int VAL_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int TDATA_W  = 48;

  // Trailer bytes.
  localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;
  localparam logic [BYTE_W-1:0] LF_BYTE = 8'h0A;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_GOOD        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_TRAILER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CHECK   = 2'd2;

  // Register indexes.
  localparam logic REG_HDR_FIRST  = 1'b0;
  localparam logic REG_HDR_SECOND = 1'b1;

  // Operations of the shared arithmetic and compare unit.
  typedef enum logic [1:0] {
    ALU_ADD8,
    ALU_EQ,
    ALU_GT
  } alu_op_e;

  typedef struct packed {
    logic              flag;
    logic [BYTE_W-1:0] sum;
  } alu_res_t;

endpackage

[src/mfdm_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module mfdm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/mfdm_alu.sv]
// ----------------------------------------------------------------------------
// Shared arithmetic and compare unit
// One 8-bit modulo add, one 16-bit equality or one 16-bit greater-than
// compare per cycle, chosen by the sequencer.
// ----------------------------------------------------------------------------
module mfdm_alu (
  input  mfdm_pkg::alu_op_e           op_i,
  input  logic [mfdm_pkg::VAL_W-1:0]  a_i,
  input  logic [mfdm_pkg::VAL_W-1:0]  b_i,
  output mfdm_pkg::alu_res_t          res_o
);
  import mfdm_pkg::*;

  // Select the operation; the unused part of the result stays zero.
  always_comb begin
    res_o = '0;
    unique case (op_i)
      ALU_ADD8: res_o.sum  = a_i[BYTE_W-1:0] + b_i[BYTE_W-1:0];
      ALU_EQ:   res_o.flag = (a_i == b_i);
      ALU_GT:   res_o.flag = (a_i > b_i);
      default:  res_o      = '0;
    endcase
  end

endmodule

[src/matrix_frame_deframer_max.sv]
// ----------------------------------------------------------------------------
// Matrix frame deframer with peak search
// Hunts for a two-byte header, collects little-endian 16-bit points, checks
// an additive checksum and a CR LF trailer, and emits one result per point
// with the frame peak, or one status result for a bad frame.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                       Content
//  s_axis    in         tvalid tready tdata[7:0]      rx_byte
//  m_axis    out        tvalid tready tdata tuser     one result per transaction
//                       tlast                         tlast = last
//  cfg       in         cfg_we_i cfg_idx_i cfg_data_i header byte writes
//
//  A received byte is accepted and then makes one pass through the shared
//  unit, or a second pass where one is needed: the high byte of a point
//  (peak compare) and a wrong second header byte (first-byte recheck).
//  A good frame end then emits each point through a RAM read, a load and
//  an output step, held by any output stall; a bad frame gives one status
//  result. Reset is asynchronous; the point store needs no clearing pass.
//  No byte is accepted while a result is pending or a byte is in work.
//
module matrix_frame_deframer_max (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Received bytes: [7:0] rx_byte.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mfdm_pkg::BYTE_W-1:0]       s_axis_tdata,
  // Results: [3:0] point_index, [19:4] point_value, [23:20] peak_index,
  // [39:24] peak_value, [40] active, [47:41] zero.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mfdm_pkg::TDATA_W-1:0]      m_axis_tdata,
  // Result kind: [1:0] status.
  output logic [mfdm_pkg::STATUS_W-1:0]     m_axis_tuser,
  output logic                              m_axis_tlast,
  // Register writes.
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [mfdm_pkg::BYTE_W-1:0]       cfg_data_i
);
  import mfdm_pkg::*;

  `include "matrix_frame_deframer_max_macros.svh"

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OP1  = 3'd1;
  localparam logic [2:0] S_OP2  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // Where in the frame the current byte falls.
  typedef enum logic [2:0] {
    C_HUNT,
    C_SECOND,
    C_PAYLOAD,
    C_CHECK,
    C_CR,
    C_LF
  } pos_cls_e;

  logic [2:0]          state_q, state_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [BYTE_W-1:0]   byte_q, byte_d;
  logic [BYTE_W-1:0]   sum_q, sum_d;
  logic [BYTE_W-1:0]   low_q, low_d;
  logic [VAL_W-1:0]    pk_val_q, pk_val_d;
  logic [ADDR_W-1:0]   pk_idx_q, pk_idx_d;
  logic                chk_q, chk_d;
  logic                cr_q, cr_d;
  logic [ADDR_W-1:0]   emit_q, emit_d;
  logic [BYTE_W-1:0]   hdr_first_q, hdr_second_q;

  logic [STATUS_W-1:0] o_status_q, o_status_d;
  logic [PIDX_W-1:0]   o_pidx_q, o_pidx_d;
  logic [VAL_W-1:0]    o_pval_q, o_pval_d;
  logic [PIDX_W-1:0]   o_kidx_q, o_kidx_d;
  logic [VAL_W-1:0]    o_kval_q, o_kval_d;
  logic                o_act_q, o_act_d;
  logic                o_last_q, o_last_d;

  pos_cls_e            cls;
  logic [POS_W-1:0]    pos_m2;
  logic [ADDR_W-1:0]   pt_idx;
  logic [VAL_W-1:0]    pt_val;
  alu_op_e             alu_op;
  logic [VAL_W-1:0]    alu_a, alu_b;
  alu_res_t            alu_res;
  logic                ram_we, ram_re;
  logic [VAL_W-1:0]    ram_rdata;

  // Classify the byte position and form the point index and value.
  assign pos_m2 = pos_q - POS_W'(2);
  assign pt_idx = pos_m2[ADDR_W:1];
  assign pt_val = {byte_q, low_q};

  always_comb begin
    priority if (pos_q == POS_W'(0)) begin
      cls = C_HUNT;
    end else if (pos_q == POS_W'(1)) begin
      cls = C_SECOND;
    end else if (pos_q < POS_W'(CHK_POS)) begin
      cls = C_PAYLOAD;
    end else if (pos_q == POS_W'(CHK_POS)) begin
      cls = C_CHECK;
    end else if (pos_q == POS_W'(CHK_POS + 1)) begin
      cls = C_CR;
    end else begin
      cls = C_LF;
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    alu_op = ALU_ADD8;
    alu_a  = '0;
    alu_b  = '0;
    if (state_q == S_OP1) begin
      unique case (cls)
        C_HUNT: begin
          alu_op = ALU_EQ;
          alu_a  = VAL_W'(byte_q);
          alu_b  = VAL_W'(hdr_first_q);
        end
        C_SECOND: begin
          alu_op = ALU_EQ;
          alu_a  = VAL_W'(byte_q);
          alu_b  = VAL_W'(hdr_second_q);
        end
        C_PAYLOAD: begin
          alu_op = ALU_ADD8;
          alu_a  = VAL_W'(sum_q);
          alu_b  = VAL_W'(byte_q);
        end
        C_CHECK: begin
          alu_op = ALU_EQ;
          alu_a  = VAL_W'(byte_q);
          alu_b  = VAL_W'(sum_q);
        end
        C_CR: begin
          alu_op = ALU_EQ;
          alu_a  = VAL_W'(byte_q);
          alu_b  = VAL_W'(CR_BYTE);
        end
        default: begin
          alu_op = ALU_EQ;
          alu_a  = VAL_W'(byte_q);
          alu_b  = VAL_W'(LF_BYTE);
        end
      endcase
    end else if (state_q == S_OP2) begin
      if (cls == C_SECOND) begin
        alu_op = ALU_EQ;
        alu_a  = VAL_W'(byte_q);
        alu_b  = VAL_W'(hdr_first_q);
      end else begin
        alu_op = ALU_GT;
        alu_a  = pt_val;
        alu_b  = pk_val_q;
      end
    end
  end

  mfdm_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // Point store: written with the high byte of each point, read at emission.
  assign ram_we = (state_q == S_OP1) && (cls == C_PAYLOAD) && pos_q[0];
  assign ram_re = (state_q == S_RD);

  mfdm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pt_idx),
    .wdata_i (pt_val),
    .re_i    (ram_re),
    .raddr_i (emit_q),
    .rdata_o (ram_rdata)
  );

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    byte_d     = byte_q;
    sum_d      = sum_q;
    low_d      = low_q;
    pk_val_d   = pk_val_q;
    pk_idx_d   = pk_idx_q;
    chk_d      = chk_q;
    cr_d       = cr_q;
    emit_d     = emit_q;
    o_status_d = o_status_q;
    o_pidx_d   = o_pidx_q;
    o_pval_d   = o_pval_q;
    o_kidx_d   = o_kidx_q;
    o_kval_d   = o_kval_q;
    o_act_d    = o_act_q;
    o_last_d   = o_last_q;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          byte_d  = s_axis_tdata;
          state_d = S_OP1;
        end
      end

      S_OP1: begin
        state_d = S_IDLE;
        unique case (cls)
          C_HUNT: begin
            if (alu_res.flag) begin
              sum_d    = '0;
              low_d    = '0;
              pk_val_d = '0;
              pk_idx_d = '0;
              chk_d    = 1'b0;
              cr_d     = 1'b0;
              pos_d    = POS_W'(1);
            end
          end
          C_SECOND: begin
            sum_d    = '0;
            low_d    = '0;
            pk_val_d = '0;
            pk_idx_d = '0;
            chk_d    = 1'b0;
            cr_d     = 1'b0;
            if (alu_res.flag) begin
              pos_d = POS_W'(2);
            end else begin
              state_d = S_OP2;
            end
          end
          C_PAYLOAD: begin
            sum_d = alu_res.sum;
            if (pos_q[0]) begin
              state_d = S_OP2;
            end else begin
              low_d = byte_q;
              pos_d = pos_q + POS_W'(1);
            end
          end
          C_CHECK: begin
            chk_d = alu_res.flag;
            pos_d = pos_q + POS_W'(1);
          end
          C_CR: begin
            cr_d  = alu_res.flag;
            pos_d = pos_q + POS_W'(1);
          end
          default: begin
            // Final byte: judge the trailer first, then the checksum.
            pos_d = '0;
            if (!cr_q || !alu_res.flag || !chk_q) begin
              o_status_d = (!cr_q || !alu_res.flag) ? ST_BAD_TRAILER : ST_BAD_CHECK;
              o_pidx_d   = '0;
              o_pval_d   = '0;
              o_kidx_d   = '0;
              o_kval_d   = '0;
              o_act_d    = 1'b0;
              o_last_d   = 1'b1;
              state_d    = S_OUT;
            end else begin
              emit_d  = '0;
              state_d = S_RD;
            end
          end
        endcase
      end

      S_OP2: begin
        state_d = S_IDLE;
        if (cls == C_SECOND) begin
          // A wrong second byte may itself start a new header.
          pos_d = alu_res.flag ? POS_W'(1) : POS_W'(0);
        end else begin
          if (alu_res.flag) begin
            pk_val_d = pt_val;
            pk_idx_d = pt_idx;
          end
          pos_d = pos_q + POS_W'(1);
        end
      end

      S_RD: begin
        state_d = S_LOAD;
      end

      S_LOAD: begin
        o_status_d = ST_GOOD;
        o_pidx_d   = PIDX_W'(emit_q);
        o_pval_d   = ram_rdata;
        o_kidx_d   = PIDX_W'(pk_idx_q);
        o_kval_d   = pk_val_q;
        o_act_d    = |pk_val_q;
        o_last_d   = (emit_q == ADDR_W'(POINTS - 1));
        state_d    = S_OUT;
      end

      S_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if (o_last_q) begin
            state_d = S_IDLE;
          end else begin
            emit_d  = emit_q + ADDR_W'(1);
            state_d = S_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pos_q    <= '0;
      sum_q    <= '0;
      low_q    <= '0;
      pk_val_q <= '0;
      pk_idx_q <= '0;
      chk_q    <= 1'b0;
      cr_q     <= 1'b0;
      emit_q   <= '0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      low_q    <= low_d;
      pk_val_q <= pk_val_d;
      pk_idx_q <= pk_idx_d;
      chk_q    <= chk_d;
      cr_q     <= cr_d;
      emit_q   <= emit_d;
    end
  end

  // Header registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= 8'd170;
      hdr_second_q <= 8'd85;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HDR_FIRST:  hdr_first_q  <= cfg_data_i;
        REG_HDR_SECOND: hdr_second_q <= cfg_data_i;
        default:        hdr_first_q  <= hdr_first_q;
      endcase
    end
  end

  // Payload registers: the received byte and the output holding register.
  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    o_status_q <= o_status_d;
    o_pidx_q   <= o_pidx_d;
    o_pval_q   <= o_pval_d;
    o_kidx_q   <= o_kidx_d;
    o_kval_q   <= o_kval_d;
    o_act_q    <= o_act_d;
    o_last_q   <= o_last_d;
  end

  // Output packing.
  assign m_axis_tdata = {7'd0, o_act_q, o_kval_q, o_kidx_q, o_pval_q, o_pidx_q};
  assign m_axis_tuser = o_status_q;
  assign m_axis_tlast = o_last_q;

  // A result and a byte transaction are never offered together.
  `MFDM_ASSERT_SAME(a_no_overlap, m_axis_tvalid, !s_axis_tready, "ready while a result is pending")
  // Status results always close their run.
  `MFDM_ASSERT_SAME(a_status_last, m_axis_tvalid && (m_axis_tuser != ST_GOOD), m_axis_tlast,
                    "status result without last")
  // An accepted byte always goes through the shared unit before the next one.
  `MFDM_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                    "byte accepted on back-to-back cycles")
  // Good results carry the emission counter as their index.
  `MFDM_ASSERT_SAME(a_index_match, m_axis_tvalid && (m_axis_tuser == ST_GOOD),
                    m_axis_tdata[PIDX_W-1:0] == PIDX_W'(emit_q), "point index out of step")

endmodule
